@@ sv/brr_pkg.sv @@
// ----------------------------------------------------------------------------
// brr_pkg: shared types for the bounded random range reducer
// Item structs, command codes and a small helper used by the RTL and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package brr_pkg;

  // Default datapath width of the range arithmetic.
  localparam int unsigned WORD_BITS_DEF = 64;

  // Command codes of an input item.
  typedef enum logic [2:0] {
    CMD_S32  = 3'd0,
    CMD_U32  = 3'd1,
    CMD_S64  = 3'd2,
    CMD_U64  = 3'd3,
    CMD_BOOL = 3'd4
  } cmd_t;

  // One input item.
  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] range_low;
    logic [63:0] range_high;
    logic [63:0] entropy_word;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [63:0] sample;
    logic        accepted;
  } out_item_t;

  // Sign-extend the low 32 bits of a word to 64 bits.
  function automatic logic [63:0] sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

endpackage

`default_nettype wire

@@ sv/bounded_random_range_reducer.sv @@
// ----------------------------------------------------------------------------
// bounded_random_range_reducer: unbiased integer range reduction
// Orders two bounds, then reduces an entropy word into the range by rejection
// using two pipelined restoring remainder units that share one bound.
// ----------------------------------------------------------------------------
//  channel  | ports                     | handshake
//  ---------+---------------------------+-------------------------------------
//  input    | start, busy, in_item      | item taken when start && !busy
//  result   | out_valid, out_item       | one-cycle strobe, cannot be held off
//
//  A new item is taken in every cycle; busy is never raised.
//  Pipeline: one front stage, one remainder stage per two quotient bits,
//  and one output stage.
//  Synchronous active-low reset clears every valid bit; data is not reset.
//  There are no stalls: the result pipeline always advances.
`default_nettype none

module bounded_random_range_reducer #(
  parameter int unsigned WORD_BITS = brr_pkg::WORD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire brr_pkg::in_item_t in_item,
  output logic                   out_valid,
  output brr_pkg::out_item_t     out_item
);
  import brr_pkg::*;

  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned NSTG = (W + 1) / 2;
  localparam int unsigned DW   = 2 * NSTG;

  localparam logic [W-1:0] TOP = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic          valid;
    logic [2:0]    cmd;
    logic          full;
    logic [W-1:0]  lo;
    logic [W-1:0]  bound;
    logic [W-1:0]  word;
    logic [W-1:0]  rem_t;
    logic [W-1:0]  rem_w;
    logic [DW-1:0] dvd_t;
    logic [DW-1:0] dvd_w;
  } pipe_t;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Front stage: map, order bounds, form range and bound.
  pipe_t front_nxt;
  pipe_t pipe_r [NSTG+1];
  pipe_t pipe_nxt [NSTG+1];

  logic [63:0]  sa, sb;
  logic [W-1:0] a, b, lo_c, hi_c, range_c, bound_c, neg_c;

  always_comb begin
    sa = 64'd0;
    sb = 64'd0;
    case (in_item.command)
      CMD_S32: begin
        sa = sext32(in_item.range_low);
        sb = sext32(in_item.range_high);
      end
      CMD_U32: begin
        sa = {32'd0, in_item.range_low[31:0]};
        sb = {32'd0, in_item.range_high[31:0]};
      end
      default: begin
        sa = in_item.range_low;
        sb = in_item.range_high;
      end
    endcase
    a = sa[W-1:0];
    b = sb[W-1:0];
    // Flipping the top bit turns signed order into unsigned order.
    if (in_item.command == CMD_S32 || in_item.command == CMD_S64) begin
      a = a ^ TOP;
      b = b ^ TOP;
    end
    if (a > b) begin
      lo_c = b;
      hi_c = a;
    end else begin
      lo_c = a;
      hi_c = b;
    end
    range_c = hi_c - lo_c;
    bound_c = range_c + W'(1);
    neg_c   = W'(0) - bound_c;

    front_nxt       = '0;
    front_nxt.valid = start && !busy;
    front_nxt.cmd   = in_item.command;
    front_nxt.full  = &range_c;
    front_nxt.lo    = lo_c;
    front_nxt.bound = bound_c;
    front_nxt.word  = in_item.entropy_word[W-1:0];
    front_nxt.dvd_t = DW'(neg_c);
    front_nxt.dvd_w = DW'(in_item.entropy_word[W-1:0]);
  end

  assign pipe_nxt[0] = front_nxt;

  // Remainder stages: two restoring steps per stage for both dividends.
  for (genvar k = 0; k < NSTG; k++) begin : g_div
    always_comb begin
      logic [W:0] r2t, r2w;
      pipe_t      p;
      p = pipe_r[k];
      for (int j = 0; j < 2; j++) begin
        r2t = {p.rem_t, p.dvd_t[DW-1]};
        r2w = {p.rem_w, p.dvd_w[DW-1]};
        p.dvd_t = {p.dvd_t[DW-2:0], 1'b0};
        p.dvd_w = {p.dvd_w[DW-2:0], 1'b0};
        p.rem_t = (r2t >= {1'b0, p.bound}) ? W'(r2t - {1'b0, p.bound}) : r2t[W-1:0];
        p.rem_w = (r2w >= {1'b0, p.bound}) ? W'(r2w - {1'b0, p.bound}) : r2w[W-1:0];
      end
      pipe_nxt[k+1] = p;
    end
  end

  // Pipeline registers: valid bits reset, payload free-running.
  for (genvar k = 0; k <= NSTG; k++) begin : g_reg
    pipe_t stage_nxt;

    always_comb begin
      stage_nxt       = pipe_nxt[k];
      stage_nxt.valid = pipe_nxt[k].valid && rst_n;
    end

    always_ff @(posedge clk) begin
      pipe_r[k] <= stage_nxt;
    end
  end

  // Final stage: reject test, offset, map to command format; bool: word bit 0.
  pipe_t        fin;
  logic [W-1:0] r_c;
  logic         ok_c;
  logic [63:0]  s_c;
  logic         out_valid_r;
  out_item_t    out_item_r, out_item_nxt;

  assign fin = pipe_r[NSTG];

  always_comb begin
    r_c  = '0;
    ok_c = 1'b1;
    s_c  = 64'd0;
    case (fin.cmd)
      CMD_S32, CMD_U32, CMD_S64, CMD_U64: begin
        if (fin.full) begin
          r_c = fin.word;
        end else if (fin.word < fin.rem_t) begin
          ok_c = 1'b0;
        end else begin
          r_c = fin.lo + fin.rem_w;
        end
        if (ok_c && (fin.cmd == CMD_S32 || fin.cmd == CMD_S64)) begin
          r_c = r_c ^ TOP;
        end
        s_c = 64'(r_c);
        if (!ok_c) begin
          s_c = 64'd0;
        end else if (fin.cmd == CMD_S32) begin
          s_c = sext32(s_c);
        end else if (fin.cmd == CMD_U32) begin
          s_c = {32'd0, s_c[31:0]};
        end
      end
      CMD_BOOL: begin
        s_c = {63'd0, fin.word[0]};
      end
      default: begin
        s_c = 64'd0;
      end
    endcase
    out_item_nxt.sample   = s_c;
    out_item_nxt.accepted = ok_c;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin.valid;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

@@ sv/brr_checker.sv @@
// ----------------------------------------------------------------------------
// brr_checker: port-level checks for the bounded random range reducer
// Watches the top level's ports and flags latency and result-format slips.
// ----------------------------------------------------------------------------
`default_nettype none

module brr_checker #(
  parameter int unsigned WORD_BITS = brr_pkg::WORD_BITS_DEF
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire brr_pkg::in_item_t in_item,
  input wire logic              out_valid,
  input wire brr_pkg::out_item_t out_item
);
  import brr_pkg::*;

  localparam int unsigned LAT = (WORD_BITS + 1) / 2 + 2;

  // The block takes an item in every cycle.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Every result comes from an item taken a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

  // A bool item gives an accepted single-bit sample.
  a_bool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_item.command, LAT) == CMD_BOOL) |->
      (out_item.accepted && out_item.sample[63:1] == 63'd0))
    else $error("bad bool result");

  // A rejected word carries a zero sample.
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.accepted) |-> (out_item.sample == 64'd0))
    else $error("rejected item with nonzero sample");

endmodule

bind bounded_random_range_reducer brr_checker #(.WORD_BITS(WORD_BITS)) u_brr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_item (out_item)
);

`default_nettype wire
